// ----- rtl/core/bfsp_pkg.sv -----
// Shared types and codes for the shortest path core.
`timescale 1ns / 1ps
package bfsp_pkg;
  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;
  localparam logic [1:0] ST_ALL_REACHED = 2'd0;
  localparam logic [1:0] ST_UNREACHED   = 2'd1;
  localparam logic [1:0] ST_NEG_CYCLE   = 2'd2;
  localparam logic CFG_VERTEX_COUNT = 1'b0;
  localparam logic CFG_SOURCE       = 1'b1;
endpackage

// ----- rtl/core/bellman_ford_shortest_paths_core.sv -----
// Top level of the single source shortest path core.
`timescale 1ns / 1ps
// Usage:
//  Input channel (in_valid/in_ready) takes one edge word per cycle:
//  edge_from, edge_to, edge_weight, last_edge. Edges with an endpoint at
//  or beyond vertex_count, or beyond the store depth, are dropped and
//  flagged. The word with last_edge set queues a job for the back end.
//  While a job is pending or running, in_ready is low.
//  The back end clears the reached bits but the source's, then relaxes every
//  edge once per vertex but one and checks once more, with a fetch, read and
//  apply step per edge on the registered edge store and distance memory.
//  Output channel (out_valid/out_ready) carries one status word per graph
//  (status, bad_edge, edges_used); it holds until taken.
//  Configuration: cfg_we writes cfg_data to register cfg_addr (0 vertex
//  count, 1 source). Write only while idle.
//  Reset (rst, synchronous) empties the store and clears flags.
module bellman_ford_shortest_paths_core import bfsp_pkg::*; #(
  parameter int WEIGHT_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_addr,
  input  logic [6:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [5:0] edge_from,
  input  logic [5:0] edge_to,
  input  logic [WEIGHT_BITS-1:0] edge_weight,
  input  logic last_edge,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] status,
  output logic bad_edge,
  output logic [8:0] edges_used
);
  localparam int VB = $clog2(MAX_VERTICES);
  localparam int EB = $clog2(MAX_EDGES);
  localparam int CB = EB + 1;
  logic [6:0] vcount;
  logic [5:0] src;
  logic [VB:0] n_act;
  logic [EB-1:0] rd_addr;
  logic [2*VB+WEIGHT_BITS-1:0] rd_data;
  logic job_valid, job_take, job_bad, busy;
  logic [CB-1:0] job_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= 7'd1;
      src <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_VERTEX_COUNT) vcount <= cfg_data;
      else src <= cfg_data[5:0];
    end
  end
  // zero counts as one, anything above the maximum clips
  assign n_act = (vcount == 7'd0) ? 7'd1 : (vcount > 7'(MAX_VERTICES)) ?
                 7'(MAX_VERTICES) : vcount;

  bfsp_front #(.VB(VB), .EB(EB), .CB(CB), .WB(WEIGHT_BITS)) u_front (
    .clk, .rst, .edge_from, .edge_to, .edge_weight, .last_edge, .in_valid,
    .in_ready, .n_act, .rd_addr, .rd_data, .job_valid, .job_take, .busy,
    .job_count, .job_bad
  );
  bfsp_back #(.VB(VB), .EB(EB), .CB(CB), .WB(WEIGHT_BITS)) u_back (
    .clk, .rst, .n_act, .src, .job_valid, .job_take, .busy, .job_count, .job_bad,
    .rd_addr, .rd_data, .status, .bad_edge, .edges_used, .out_valid, .out_ready
  );
endmodule

// ----- rtl/core/bfsp_front.sv -----
// Front end: edge intake, range check, edge store and job queue.
`timescale 1ns / 1ps
module bfsp_front import bfsp_pkg::*; #(
  parameter int VB = 6,
  parameter int EB = 8,
  parameter int CB = 9,
  parameter int WB = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [VB-1:0] edge_from,
  input  logic [VB-1:0] edge_to,
  input  logic [WB-1:0] edge_weight,
  input  logic          last_edge,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [VB:0]   n_act,
  input  logic [EB-1:0] rd_addr,
  output logic [2*VB+WB-1:0] rd_data,
  output logic          job_valid,
  input  logic          job_take,
  input  logic          busy,
  output logic [CB-1:0] job_count,
  output logic          job_bad
);
  localparam int MaxE = 1 << EB;
  logic [2*VB+WB-1:0] mem [MaxE];
  logic [CB-1:0] edge_count;
  logic dropped;
  logic acc, drop;

  // The store is owned by the back end while a job is queued or running.
  assign in_ready = !job_valid && !busy;
  assign acc = in_valid && in_ready;
  assign drop = ({1'b0, edge_from} >= n_act) || ({1'b0, edge_to} >= n_act) ||
                (edge_count >= CB'(MaxE));

  always_ff @(posedge clk) begin
    if (acc && !drop) mem[edge_count[EB-1:0]] <= {edge_from, edge_to, edge_weight};
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= '0;
      dropped <= 1'b0;
      job_valid <= 1'b0;
      job_count <= '0;
      job_bad <= 1'b0;
    end else begin
      if (job_take) job_valid <= 1'b0;
      if (acc) begin
        if (last_edge) begin
          job_valid <= 1'b1;
          job_count <= edge_count + CB'(!drop);
          job_bad <= dropped || drop;
          edge_count <= '0;
          dropped <= 1'b0;
        end else begin
          if (!drop) edge_count <= edge_count + 1'b1;
          if (drop) dropped <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- rtl/core/bfsp_back.sv -----
// Back end: relaxation sequencer, distance memory and result register.
`timescale 1ns / 1ps
module bfsp_back import bfsp_pkg::*; #(
  parameter int VB = 6,
  parameter int EB = 8,
  parameter int CB = 9,
  parameter int WB = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [VB:0]   n_act,
  input  logic [VB-1:0] src,
  input  logic          job_valid,
  output logic          job_take,
  output logic          busy,
  input  logic [CB-1:0] job_count,
  input  logic          job_bad,
  output logic [EB-1:0] rd_addr,
  input  logic [2*VB+WB-1:0] rd_data,
  output logic [1:0]    status,
  output logic          bad_edge,
  output logic [CB-1:0] edges_used,
  output logic          out_valid,
  input  logic          out_ready
);
  localparam int NV = 1 << VB;
  typedef enum logic [2:0] {S_IDLE, S_CLR, S_FETCH, S_READ, S_APPLY, S_SCAN, S_DONE}
    state_t;
  state_t state;
  logic [31:0] dist_mem [NV];
  logic [NV-1:0] reached;
  logic [VB:0] pass, vi;
  logic [CB-1:0] k, cnt;
  logic check, bad;
  logic [VB-1:0] eu, ev;
  logic [WB-1:0] ew;
  logic [31:0] du, dv;
  logic ru, rv, inr;
  logic [33:0] sum;
  logic [31:0] sat;
  logic relax;

  assign {eu, ev, ew} = rd_data;
  assign rd_addr = k[EB-1:0];
  assign job_take = (state == S_IDLE) && job_valid && !out_valid;
  assign busy = (state != S_IDLE);
  assign sum = {{2{du[31]}}, du} + {{(34-WB){ew[WB-1]}}, ew};
  assign relax = inr && ru && (!rv || ($signed(sum) < $signed({{2{dv[31]}}, dv})));
  always_comb begin
    if (sum[33] && !sum[31]) sat = 32'h8000_0000;
    else if (!sum[33] && sum[31]) sat = 32'h7fff_ffff;
    else sat = sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      reached <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (job_take) begin
          cnt <= job_count;
          bad <= job_bad;
          reached <= ({1'b0, src} < n_act) ? (NV'(1) << src) : '0;
          dist_mem[src] <= '0;
          pass <= '0;
          k <= '0;
          check <= 1'b0;
          state <= S_FETCH;
        end
        S_CLR: state <= S_FETCH;
        S_FETCH: begin
          if (k >= cnt) begin
            if (check || pass + 1'b1 >= n_act) begin
              if (check) begin
                vi <= '0;
                state <= S_SCAN;
              end else begin
                check <= 1'b1;
                k <= '0;
              end
            end else begin
              pass <= pass + 1'b1;
              k <= '0;
            end
          end else state <= S_READ;
        end
        S_READ: begin
          du <= dist_mem[eu];
          dv <= dist_mem[ev];
          ru <= reached[eu];
          rv <= reached[ev];
          inr <= ({1'b0, eu} < n_act) && ({1'b0, ev} < n_act);
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (relax && check) begin
            status <= ST_NEG_CYCLE;
            state <= S_DONE;
          end else begin
            if (relax) begin
              dist_mem[ev] <= sat;
              reached[ev] <= 1'b1;
            end
            k <= k + 1'b1;
            state <= S_FETCH;
          end
        end
        S_SCAN: begin
          if (vi >= n_act) begin
            status <= ST_ALL_REACHED;
            state <= S_DONE;
          end else if (!reached[vi[VB-1:0]]) begin
            status <= ST_UNREACHED;
            state <= S_DONE;
          end else vi <= vi + 1'b1;
        end
        S_DONE: if (!out_valid) begin
          out_valid <= 1'b1;
          bad_edge <= bad;
          edges_used <= cnt;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
